### rtl/sbgm_pkg.sv
// shared widths, register codes, reset values and sigmoid table helper for the gain map
`default_nettype none

package sbgm_pkg;

    localparam int GRAD_W     = 16;
    localparam int INV_W      = 32;
    localparam int SLOPE_W    = 12;
    localparam int EXTRA_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // g * inv and (g * inv) * slope
    localparam int GI_W       = GRAD_W + INV_W;
    localparam int GIS_W      = GI_W + SLOPE_W;
    // biased argument, signed, and its in-range span [0, 16) in Q.34
    localparam int ARG_X_W    = GIS_W + 2;
    localparam int ARG_W      = 38;
    localparam int ONE_SHIFT  = 26;

    // sigmoid values in Q.16, up to and including 1.0
    localparam int SIG_W      = 17;
    localparam logic [SIG_W-1:0] SIG_ONE = 17'h10000;
    // extra_gain times fall, signed
    localparam int EF_W       = EXTRA_W + SIG_W + 1;

    localparam int DEF_LUT_ENTRIES    = 256;
    localparam int DEF_GAIN_FRAC_BITS = 12;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    localparam logic [INV_W-1:0]   RST_INV_LO = 32'd65536;
    localparam logic [INV_W-1:0]   RST_INV_HI = 32'd6554;
    localparam logic [SLOPE_W-1:0] RST_SLOPE  = 12'd512;
    localparam logic [EXTRA_W-1:0] RST_EXTRA  = 16'd20480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_MODE = 3'd0,
        CFG_INV_LO   = 3'd1,
        CFG_INV_HI   = 3'd2,
        CFG_SLOPE    = 3'd3,
        CFG_EXTRA    = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        MODE_GAIN   = 1'b0,
        MODE_WEIGHT = 1'b1
    } t_map_mode;

    typedef struct packed {
        logic below;
        logic above;
    } t_edge_sat;

    // e^-a for a in Q.30, 0 <= a <= 8.0, result in Q.30; evaluated at elaboration only
    function automatic longint unsigned exp_neg_q30(input longint unsigned a);
        longint unsigned r;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned t4;
        longint unsigned e;
        r  = a >> 8;
        t2 = (r * r) >> 30;
        t3 = (t2 * r) >> 30;
        t4 = (t3 * r) >> 30;
        e  = Q30_ONE - r + t2 / 2 + t4 / 24 - t3 / 6;
        for (int k = 0; k < 8; k++) begin
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/sbgm_sig_rom.sv
// sigmoid table built at elaboration, two combinational read ports
`default_nettype none

module sbgm_sig_rom #(
    parameter int LUT_ENTRIES = sbgm_pkg::DEF_LUT_ENTRIES
) (
    input  logic [$clog2(LUT_ENTRIES)-1:0] i_rise_idx,
    input  logic [$clog2(LUT_ENTRIES)-1:0] i_fall_idx,
    output logic [sbgm_pkg::SIG_W-1:0]     o_rise_val,
    output logic [sbgm_pkg::SIG_W-1:0]     o_fall_val
);
    import sbgm_pkg::*;

    logic [SIG_W-1:0] rom_data [LUT_ENTRIES];

    // entry i holds the sigmoid at the bin centre -8 + 16*(i+0.5)/N
    for (genvar i = 0; i < LUT_ENTRIES; i++) begin : g_entry
        localparam longint NUM = longint'(8 * (2 * i + 1 - LUT_ENTRIES));
        localparam longint unsigned MAG = (NUM < 0) ? longint'(-NUM) : longint'(NUM);
        localparam longint unsigned ARG = (MAG << 30) / LUT_ENTRIES;
        localparam longint unsigned EXPV = exp_neg_q30(ARG);
        localparam longint unsigned DEN = Q30_ONE + EXPV;
        localparam longint unsigned VAL = (NUM >= 0) ?
            (((64'd1 << 46) + DEN / 2) / DEN) :
            (((EXPV << 16) + DEN / 2) / DEN);
        assign rom_data[i] = SIG_W'(VAL);
    end

    assign o_rise_val = rom_data[i_rise_idx];
    assign o_fall_val = rom_data[i_fall_idx];

endmodule

`default_nettype wire

### rtl/sbgm_edge_arg.sv
// four-stage edge argument path: g*inv, times slope, bias and range check, table index
`default_nettype none

module sbgm_edge_arg #(
    parameter int LUT_ENTRIES = sbgm_pkg::DEF_LUT_ENTRIES,
    parameter bit IS_FALL     = 1'b0
) (
    input  logic                           i_clk,
    input  logic [3:0]                     i_en,
    input  logic [sbgm_pkg::GRAD_W-1:0]    i_gradient_magnitude,
    input  logic [sbgm_pkg::INV_W-1:0]     i_inv,
    input  logic [sbgm_pkg::SLOPE_W-1:0]   i_slope,
    output logic [$clog2(LUT_ENTRIES)-1:0] o_idx,
    output sbgm_pkg::t_edge_sat            o_sat
);
    import sbgm_pkg::*;

    localparam int IDX_W = $clog2(LUT_ENTRIES);
    localparam int LUT_W = $clog2(LUT_ENTRIES + 1);
    localparam int SC_W  = ARG_W + LUT_W;
    localparam logic [ARG_X_W-1:0] ARG_BIAS = ARG_X_W'(1) << (ARG_W - 1);

    logic [GI_W-1:0]    r_gi;
    logic [GIS_W-1:0]   r_gis;
    logic [ARG_W-1:0]   r_x;
    t_edge_sat          r_sat3;
    logic [IDX_W-1:0]   r_idx;
    t_edge_sat          r_sat4;

    logic [ARG_X_W-1:0] slope_one;
    logic [ARG_X_W-1:0] n_x_full;
    t_edge_sat          n_sat3;
    logic [SC_W-1:0]    n_scaled;

    // slope * 1.0 in Q.34; the fall edge uses the negated argument
    assign slope_one = ARG_X_W'(i_slope) << ONE_SHIFT;
    assign n_x_full  = IS_FALL ? (ARG_BIAS + slope_one - ARG_X_W'(r_gis))
                               : (ARG_BIAS - slope_one + ARG_X_W'(r_gis));

    assign n_sat3.below = n_x_full[ARG_X_W-1];
    assign n_sat3.above = !n_x_full[ARG_X_W-1] && (n_x_full[ARG_X_W-2:ARG_W] != '0);

    assign n_scaled = SC_W'(r_x) * SC_W'(LUT_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_gi <= GI_W'(i_gradient_magnitude) * GI_W'(i_inv);
        end
        if (i_en[1]) begin
            r_gis <= GIS_W'(r_gi) * GIS_W'(i_slope);
        end
        if (i_en[2]) begin
            r_x    <= n_x_full[ARG_W-1:0];
            r_sat3 <= n_sat3;
        end
        if (i_en[3]) begin
            r_idx  <= n_scaled[ARG_W +: IDX_W];
            r_sat4 <= r_sat3;
        end
    end

    assign o_idx = r_idx;
    assign o_sat = r_sat4;

endmodule

`default_nettype wire

### rtl/sigmoid_band_gain_map.sv
// top level: configuration registers, pipeline control, table read and gain combine
//
// one gradient sample in, one gain or weight out, in order
// input channel: i_valid / o_stall with i_gradient_magnitude (unsigned Q6.10)
// output channel: o_valid / i_stall with o_gain_value (unsigned Q4.12, at most 8.0)
// a transfer happens on a rising edge with valid high and stall low
// eight register stages lie between the input transfer and the output, and
// one sample per clock is taken and delivered when unstalled
// the rate is set by the two multipliers of each edge path and the final
// gain multiplier, each given a stage of its own
// configuration: i_cfg_we, i_cfg_idx, i_cfg_data; index 0 map mode, 1 and 2
// the two threshold inverses, 3 slope, 4 extra gain; other indexes are ignored
// reset clears every stage valid bit and loads the register defaults;
// there is no clearing pass, the sigmoid table is constant
// when i_stall holds the output, stages behind it keep filling until every
// stage is full, and only then is o_stall raised; nothing is lost or repeated
`default_nettype none

module sigmoid_band_gain_map #(
    parameter int SIGMOID_LUT_ENTRIES = sbgm_pkg::DEF_LUT_ENTRIES,
    parameter int GAIN_FRAC_BITS      = sbgm_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sbgm_pkg::GRAD_W-1:0]       i_gradient_magnitude,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sbgm_pkg::GAIN_W-1:0]       o_gain_value,
    input  logic                              i_cfg_we,
    input  logic [sbgm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sbgm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sbgm_pkg::*;

    localparam int NUM_STAGES = 8;
    localparam int IDX_W      = $clog2(SIGMOID_LUT_ENTRIES);
    localparam int INNER_W    = ((GAIN_FRAC_BITS + 16 > 31) ? GAIN_FRAC_BITS + 16 : 31) + 2;
    localparam int PROD_W     = INNER_W + SIG_W + 1;
    localparam int RES_W      = PROD_W - 32;
    localparam int GAIN_CAP   = ((8 << GAIN_FRAC_BITS) > 65535) ? 65535 : (8 << GAIN_FRAC_BITS);
    localparam logic signed [INNER_W-1:0] INNER_ONE =
        INNER_W'(1) << (GAIN_FRAC_BITS + 16);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 31;

    // configuration registers
    t_map_mode                  r_map_mode;
    logic [INV_W-1:0]           r_inv_lo;
    logic [INV_W-1:0]           r_inv_hi;
    logic [SLOPE_W-1:0]         r_slope;
    logic signed [EXTRA_W-1:0]  r_extra;

    // pipeline control
    logic [NUM_STAGES:1]        r_valid;
    logic [NUM_STAGES:1]        stage_en;

    // edge paths and table
    logic [IDX_W-1:0]           rise_idx;
    logic [IDX_W-1:0]           fall_idx;
    t_edge_sat                  rise_sat;
    t_edge_sat                  fall_sat;
    logic [SIG_W-1:0]           rise_raw;
    logic [SIG_W-1:0]           fall_raw;

    // combine stages
    logic [SIG_W-1:0]           r_rise5;
    logic [SIG_W-1:0]           r_fall5;
    logic [SIG_W-1:0]           n_rise5;
    logic [SIG_W-1:0]           n_fall5;
    logic signed [INNER_W-1:0]  r_inner;
    logic signed [INNER_W-1:0]  n_inner;
    logic [SIG_W-1:0]           r_rise6;
    logic signed [PROD_W-1:0]   r_prod;
    logic [GAIN_W-1:0]          r_gain;
    logic [GAIN_W-1:0]          n_gain;

    logic signed [EF_W-1:0]     ext_s;
    logic signed [EF_W-1:0]     fall_s;
    logic signed [EF_W-1:0]     extra_fall;
    logic [PROD_W-1:0]          rounded;
    logic [RES_W-1:0]           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode <= MODE_GAIN;
            r_inv_lo   <= RST_INV_LO;
            r_inv_hi   <= RST_INV_HI;
            r_slope    <= RST_SLOPE;
            r_extra    <= RST_EXTRA;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_MAP_MODE: r_map_mode <= t_map_mode'(i_cfg_data[0]);
                CFG_INV_LO:   r_inv_lo   <= i_cfg_data[INV_W-1:0];
                CFG_INV_HI:   r_inv_hi   <= i_cfg_data[INV_W-1:0];
                CFG_SLOPE:    r_slope    <= i_cfg_data[SLOPE_W-1:0];
                CFG_EXTRA:    r_extra    <= i_cfg_data[EXTRA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage moves on when it is empty or the stage after it moves on
    always_comb begin
        stage_en[NUM_STAGES] = !r_valid[NUM_STAGES] || !i_stall;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (stage_en[1]) begin
                r_valid[1] <= i_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    sbgm_edge_arg #(
        .LUT_ENTRIES (SIGMOID_LUT_ENTRIES),
        .IS_FALL     (1'b0)
    ) u_rise_arg (
        .i_clk                (i_clk),
        .i_en                 (stage_en[4:1]),
        .i_gradient_magnitude (i_gradient_magnitude),
        .i_inv                (r_inv_lo),
        .i_slope              (r_slope),
        .o_idx                (rise_idx),
        .o_sat                (rise_sat)
    );

    sbgm_edge_arg #(
        .LUT_ENTRIES (SIGMOID_LUT_ENTRIES),
        .IS_FALL     (1'b1)
    ) u_fall_arg (
        .i_clk                (i_clk),
        .i_en                 (stage_en[4:1]),
        .i_gradient_magnitude (i_gradient_magnitude),
        .i_inv                (r_inv_hi),
        .i_slope              (r_slope),
        .o_idx                (fall_idx),
        .o_sat                (fall_sat)
    );

    sbgm_sig_rom #(
        .LUT_ENTRIES (SIGMOID_LUT_ENTRIES)
    ) u_sig_rom (
        .i_rise_idx (rise_idx),
        .i_fall_idx (fall_idx),
        .o_rise_val (rise_raw),
        .o_fall_val (fall_raw)
    );

    // outside the table range the sigmoid saturates
    assign n_rise5 = rise_sat.below ? '0 : (rise_sat.above ? SIG_ONE : rise_raw);
    assign n_fall5 = fall_sat.below ? '0 : (fall_sat.above ? SIG_ONE : fall_raw);

    assign ext_s      = EF_W'(r_extra);
    assign fall_s     = EF_W'(signed'({1'b0, r_fall5}));
    assign extra_fall = ext_s * fall_s;

    always_comb begin
        unique case (r_map_mode)
            MODE_WEIGHT: n_inner = INNER_W'(signed'({1'b0, r_fall5})) <<< GAIN_FRAC_BITS;
            MODE_GAIN:   n_inner = INNER_ONE + INNER_W'(extra_fall);
            default:     n_inner = INNER_ONE + INNER_W'(extra_fall);
        endcase
    end

    // round half up to GAIN_FRAC_BITS, then clamp to [0, 8.0]
    assign rounded = PROD_W'(r_prod) + ROUND_HALF;
    assign res     = rounded[PROD_W-1:32];

    always_comb begin
        if (r_prod[PROD_W-1] || (r_prod == '0)) begin
            n_gain = '0;
        end else if (res > RES_W'(GAIN_CAP)) begin
            n_gain = GAIN_W'(GAIN_CAP);
        end else begin
            n_gain = res[GAIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_rise5 <= n_rise5;
            r_fall5 <= n_fall5;
        end
        if (stage_en[6]) begin
            r_inner <= n_inner;
            r_rise6 <= r_rise5;
        end
        if (stage_en[7]) begin
            r_prod <= PROD_W'(r_inner) * PROD_W'(signed'({1'b0, r_rise6}));
        end
        if (stage_en[8]) begin
            r_gain <= n_gain;
        end
    end

    assign o_valid      = r_valid[NUM_STAGES];
    assign o_gain_value = r_gain;

`ifndef SYNTH
    // input is held back only when every stage is occupied and the output stalls
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_valid) && i_stall))
        else $error("input stalled with room in the pipeline");

    // a transfer in always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_valid[1])
        else $error("accepted sample lost at pipeline entry");

    // a table argument cannot lie both below and above the range
    a_sat_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rise_sat.below && rise_sat.above) && !(fall_sat.below && fall_sat.above))
        else $error("sigmoid range flags both set");

    // delivered gain never exceeds the clamp
    a_gain_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain_value <= GAIN_W'(GAIN_CAP)))
        else $error("gain above saturation limit");
`endif

endmodule

`default_nettype wire
